// File: design/kdlp_pkg.sv
// Shared types and constants for the key debounce block with event queue.
package kdlp_pkg;

   localparam int KEY_COUNT = 4;
   localparam int PIN_COUNT = 3;
   localparam int FIFO_DEPTH_DEFAULT = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 12;

   localparam logic [1:0] COMBO_KEY = 2'd3;

   localparam logic [6:0] FILTER_TIME_RESET = 7'd5;
   localparam logic [11:0] LONG_TIME_RESET = 12'd100;
   localparam logic [7:0] REPEAT_SPEED_RESET = 8'd0;
   localparam logic [7:0] DEBOUNCE_RESET = 8'(FILTER_TIME_RESET / 2);

   typedef enum logic [1:0] {
      KIND_DOWN = 2'd0,
      KIND_UP   = 2'd1,
      KIND_LONG = 2'd2
   } event_kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FILTER_TIME  = 2'd0,
      CSR_LONG_TIME    = 2'd1,
      CSR_REPEAT_SPEED = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [1:0]     key;
      event_kind_type kind;
   } evt_code_type;

   typedef struct packed {
      logic         valid;
      evt_code_type code;
   } evt_push_type;

   typedef struct packed {
      logic [6:0]  filter_time;
      logic [11:0] long_time;
      logic [7:0]  repeat_speed;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  debounce_count;
      logic        pressed_flag;
      logic [11:0] hold_count;
      logic [7:0]  repeat_count;
   } key_state_type;

   localparam key_state_type KEY_STATE_RESET = '{
      debounce_count: DEBOUNCE_RESET,
      pressed_flag:   1'b0,
      hold_count:     12'd0,
      repeat_count:   8'd0
   };

endpackage

// File: design/kdlp_if.sv
// Channel interfaces: tick/read requests, event responses, register writes.
interface kdlp_req_if;
   logic                                valid;
   logic                                ready;
   logic                                action;
   logic [kdlp_pkg::PIN_COUNT-1:0]      pins;

   modport source (output valid, output action, output pins, input ready);
   modport sink   (input valid, input action, input pins, output ready);
endinterface

interface kdlp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_key;
   logic [1:0] event_kind;
   logic       empty_res;

   modport source (output valid, output event_key, output event_kind, output empty_res,
                   input ready);
   modport sink   (input valid, input event_key, input event_kind, input empty_res,
                   output ready);
endinterface

interface kdlp_csr_if;
   logic                                valid;
   logic                                ready;
   logic [kdlp_pkg::CSR_INDEX_W-1:0]    index;
   logic [kdlp_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/kdlp_keys.sv
// Key state memory and the per-key debounce / long press / repeat update.
module kdlp_keys (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [kdlp_pkg::PIN_COUNT-1:0] pins,
   input  kdlp_pkg::cfg_type              cfg,
   output logic                           busy,
   output kdlp_pkg::evt_push_type         push
);

   // Two slots per key: even slot issues the read, odd slot updates and writes back.
   logic [2:0]                           slot_ff, slot_in;
   logic                                 run_ff, run_in;
   logic [kdlp_pkg::PIN_COUNT-1:0]       pins_ff;

   kdlp_pkg::key_state_type              key_mem [kdlp_pkg::KEY_COUNT];
   logic [kdlp_pkg::KEY_COUNT-1:0]       key_vld_ff;
   kdlp_pkg::key_state_type              rd_data_ff;
   logic                                 rd_vld_ff;

   logic                                 pend_vld_ff;
   kdlp_pkg::evt_code_type               pend_code_ff;

   logic [1:0]                           key_id;
   logic                                 rd_en;
   logic                                 wr_en;
   logic                                 down;
   logic                                 combo;
   logic [7:0]                           ft1;
   logic [7:0]                           ft2;
   logic [11:0]                          lt;
   logic [7:0]                           rs;
   kdlp_pkg::key_state_type              cur;
   kdlp_pkg::key_state_type              nxt;
   logic                                 ev0_vld;
   logic                                 ev1_vld;
   kdlp_pkg::event_kind_type             ev0_kind;
   kdlp_pkg::event_kind_type             ev1_kind;

   assign key_id = slot_ff[2:1];
   assign rd_en  = run_ff && !slot_ff[0];
   assign wr_en  = run_ff && slot_ff[0];
   assign busy   = run_ff || pend_vld_ff;

   always_comb begin
      slot_in = slot_ff;
      run_in  = run_ff;
      if (start) begin
         slot_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         slot_in = slot_ff + 3'd1;
         if (slot_ff == 3'd7) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff     <= '0;
         run_ff      <= 1'b0;
         key_vld_ff  <= '0;
         pend_vld_ff <= 1'b0;
      end else begin
         slot_ff     <= slot_in;
         run_ff      <= run_in;
         pend_vld_ff <= wr_en && ev1_vld;
         if (wr_en) begin
            key_vld_ff[key_id] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         pins_ff <= pins;
      end
      pend_code_ff <= '{key: key_id, kind: ev1_kind};
   end

   // Each key is written back on the odd slot after its read, so read and write never overlap.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= key_mem[key_id];
         rd_vld_ff  <= key_vld_ff[key_id];
      end
      if (wr_en) begin
         key_mem[key_id] <= nxt;
      end
   end

   always_comb begin
      cur      = rd_vld_ff ? rd_data_ff : kdlp_pkg::KEY_STATE_RESET;
      combo    = (key_id == kdlp_pkg::COMBO_KEY);
      ft1      = {1'b0, cfg.filter_time};
      ft2      = {cfg.filter_time, 1'b0};
      lt       = combo ? 12'd0 : cfg.long_time;
      rs       = combo ? 8'd0 : cfg.repeat_speed;
      case (key_id)
         2'd0:    down = !pins_ff[0];
         2'd1:    down = !pins_ff[1];
         2'd2:    down = !pins_ff[2];
         default: down = !pins_ff[0] && !pins_ff[1];
      endcase
      nxt      = cur;
      ev0_vld  = 1'b0;
      ev1_vld  = 1'b0;
      ev0_kind = kdlp_pkg::KIND_DOWN;
      ev1_kind = kdlp_pkg::KIND_DOWN;
      if (down) begin
         if (cur.debounce_count < ft1) begin
            nxt.debounce_count = ft1;
         end else if (cur.debounce_count < ft2) begin
            nxt.debounce_count = cur.debounce_count + 8'd1;
         end else begin
            if (!cur.pressed_flag) begin
               nxt.pressed_flag = 1'b1;
               ev0_vld          = 1'b1;
               ev0_kind         = kdlp_pkg::KIND_DOWN;
            end
            if (lt != 12'd0) begin
               if (cur.hold_count < lt) begin
                  nxt.hold_count = cur.hold_count + 12'd1;
                  if (nxt.hold_count == lt) begin
                     // long may follow the down event of the same tick
                     if (ev0_vld) begin
                        ev1_vld  = 1'b1;
                        ev1_kind = kdlp_pkg::KIND_LONG;
                     end else begin
                        ev0_vld  = 1'b1;
                        ev0_kind = kdlp_pkg::KIND_LONG;
                     end
                  end
               end else if (rs != 8'd0) begin
                  nxt.repeat_count = cur.repeat_count + 8'd1;
                  if (nxt.repeat_count >= rs) begin
                     nxt.repeat_count = 8'd0;
                     if (ev0_vld) begin
                        ev1_vld  = 1'b1;
                        ev1_kind = kdlp_pkg::KIND_DOWN;
                     end else begin
                        ev0_vld  = 1'b1;
                        ev0_kind = kdlp_pkg::KIND_DOWN;
                     end
                  end
               end
            end
         end
      end else begin
         if (cur.debounce_count > ft1) begin
            nxt.debounce_count = ft1;
         end else if (cur.debounce_count != 8'd0) begin
            nxt.debounce_count = cur.debounce_count - 8'd1;
         end else if (cur.pressed_flag) begin
            nxt.pressed_flag = 1'b0;
            ev0_vld          = !combo;
            ev0_kind         = kdlp_pkg::KIND_UP;
         end
         nxt.hold_count   = 12'd0;
         nxt.repeat_count = 8'd0;
      end
   end

   // First event goes out on the update slot, a second one on the following slot.
   always_comb begin
      push.valid = (wr_en && ev0_vld) || pend_vld_ff;
      push.code  = pend_vld_ff ? pend_code_ff :
                   kdlp_pkg::evt_code_type'{key: key_id, kind: ev0_kind};
   end

endmodule

// File: design/kdlp_fifo.sv
// Event ring buffer: one memory, fill count, drops pushes when full.
module kdlp_fifo #(
   parameter int DEPTH = kdlp_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  kdlp_pkg::evt_push_type       push,
   input  logic                         pop,
   output logic                         empty,
   output kdlp_pkg::evt_code_type       pop_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   kdlp_pkg::evt_code_type  evt_mem [DEPTH];
   kdlp_pkg::evt_code_type  pop_data_ff;
   logic [AW-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]           fill_ff, fill_in;
   logic                    do_push;
   logic                    do_pop;

   assign empty    = (fill_ff == '0);
   assign do_push  = push.valid && (fill_ff != CW'(DEPTH));
   assign do_pop   = pop && !empty;
   assign pop_data = pop_data_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         evt_mem[wr_ptr_ff] <= push.code;
      end
      if (do_pop) begin
         pop_data_ff <= evt_mem[rd_ptr_ff];
      end
   end

endmodule

// File: design/key_debounce_long_press_fifo.sv
// Top level: key debounce with long press and repeat, events queued in a FIFO.
// A tick item (action 0) samples three active-low key pins and holds off the next
// item until the key update is through: keys 0, 1, 2 and the combination key
// (0 and 1 both down) are updated in turn, through the single-port key state
// memory, and their events (up to seven per tick) are written to the FIFO one per
// cycle. A read item (action 1) pops one event, or reports empty, and is taken one
// per cycle while no tick runs and the response path is free; its result passes
// through a read stage and an output register. Events arriving at a full FIFO are
// dropped. The user must write registers only while idle; the block does not
// itself enforce it. A write to an unknown index is ignored.
module key_debounce_long_press_fifo #(
   parameter int FIFO_DEPTH = kdlp_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   kdlp_req_if.sink      req_bus,
   kdlp_rsp_if.source    rsp_bus,
   kdlp_csr_if.sink      csr_bus
);

   kdlp_pkg::cfg_type        cfg_ff;
   kdlp_pkg::evt_push_type   push;
   kdlp_pkg::evt_code_type   pop_data;
   logic                     keys_busy;
   logic                     fifo_empty;
   logic                     req_xfer;
   logic                     tick_start;
   logic                     pop_req;
   logic                     p_vld_ff;
   logic                     p_empty_ff;
   logic                     p_free;
   logic                     rsp_load;
   logic                     rsp_vld_ff;
   logic [1:0]               rsp_key_ff;
   logic [1:0]               rsp_kind_ff;
   logic                     rsp_empty_ff;

   assign rsp_load   = p_vld_ff && (!rsp_vld_ff || rsp_bus.ready);
   assign p_free     = !p_vld_ff || rsp_load;
   assign req_bus.ready = !keys_busy && p_free;
   assign req_xfer   = req_bus.valid && req_bus.ready;
   assign tick_start = req_xfer && !req_bus.action;
   assign pop_req    = req_xfer && req_bus.action;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_time  <= kdlp_pkg::FILTER_TIME_RESET;
         cfg_ff.long_time    <= kdlp_pkg::LONG_TIME_RESET;
         cfg_ff.repeat_speed <= kdlp_pkg::REPEAT_SPEED_RESET;
      end else if (csr_bus.valid) begin
         unique case (kdlp_pkg::csr_index_type'(csr_bus.index))
            kdlp_pkg::CSR_FILTER_TIME:  cfg_ff.filter_time  <= csr_bus.data[6:0];
            kdlp_pkg::CSR_LONG_TIME:    cfg_ff.long_time    <= csr_bus.data[11:0];
            kdlp_pkg::CSR_REPEAT_SPEED: cfg_ff.repeat_speed <= csr_bus.data[7:0];
            default: ;
         endcase
      end
   end

   kdlp_keys u_keys (
      .clock (clock),
      .reset (reset),
      .start (tick_start),
      .pins  (req_bus.pins),
      .cfg   (cfg_ff),
      .busy  (keys_busy),
      .push  (push)
   );

   kdlp_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .pop      (pop_req),
      .empty    (fifo_empty),
      .pop_data (pop_data)
   );

   // Read stage waits for the registered FIFO data; output register parts the sides.
   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (pop_req) begin
            p_vld_ff <= 1'b1;
         end else if (rsp_load) begin
            p_vld_ff <= 1'b0;
         end
         if (rsp_load) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop_req) begin
         p_empty_ff <= fifo_empty;
      end
      if (rsp_load) begin
         rsp_key_ff   <= p_empty_ff ? 2'd0 : pop_data.key;
         rsp_kind_ff  <= p_empty_ff ? 2'd0 : pop_data.kind;
         rsp_empty_ff <= p_empty_ff;
      end
   end

   assign rsp_bus.valid      = rsp_vld_ff;
   assign rsp_bus.event_key  = rsp_key_ff;
   assign rsp_bus.event_kind = rsp_kind_ff;
   assign rsp_bus.empty_res  = rsp_empty_ff;

endmodule
